>>> sv/gvsp_pkg.sv
package gvsp_pkg;

  localparam int ACT_W   = 4;
  localparam int IDX_W   = 6;
  localparam int GEN_W   = 16;
  localparam int VAL_W   = 31;
  localparam int STAT_W  = 2;
  localparam int PLAY_W  = 2;
  localparam int POS_W   = 31;
  localparam int PITCH_W = 12;
  localparam int VOL_W   = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  // Q8 times Q8 pitch product, then times the Q8 tick step.
  localparam int PM_W      = 2 * PITCH_W;
  localparam int PROD_W    = VAL_W + PM_W;
  localparam int TICK_FRAC = 24;

  localparam logic [PITCH_W-1:0] PITCH_UNITY = 12'd256;
  localparam logic [PITCH_W-1:0] PITCH_MAX   = 12'd2560;
  localparam logic [VOL_W-1:0]   VOL_UNITY   = 9'd256;
  localparam logic [POS_W-1:0]   POS_MAX     = 31'h7FFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_PITCH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_PAUSE = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE   = 4'd0,
    ACT_RELEASE  = 4'd1,
    ACT_PLAY     = 4'd2,
    ACT_PAUSE    = 4'd3,
    ACT_STOP     = 4'd4,
    ACT_PITCH    = 4'd5,
    ACT_VOLUME   = 4'd6,
    ACT_POSITION = 4'd7,
    ACT_QUERY    = 4'd8,
    ACT_TICK     = 4'd9,
    ACT_STOP_ALL = 4'd10
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  typedef enum logic [PLAY_W-1:0] {
    PLAY_STOP  = 2'd0,
    PLAY_RUN   = 2'd1,
    PLAY_PAUSE = 2'd2
  } play_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_EXEC,
    S_POP,
    S_CREATE,
    S_WRD,
    S_WCHK,
    S_WM1,
    S_WM2,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] slot_index;
    logic [GEN_W-1:0] generation;
    logic             auto_play;
    logic [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   out_index;
    logic [GEN_W-1:0]   out_generation;
    logic [PLAY_W-1:0]  play_state;
    logic [POS_W-1:0]   position_ms;
    logic [PITCH_W-1:0] pitch_out;
    logic [VOL_W-1:0]   volume_out;
  } out_t;

  typedef struct packed {
    logic ld_pm;
    logic ld_prod;
  } mac_ctrl_t;

endpackage

>>> sv/generational_voice_slot_pool.sv
// Channel  Dir  Handshake                 Payload
// in       in   in_valid_i / in_ready_o    in_data_i  (gvsp_pkg::in_t)
// out      out  out_valid_o / out_ready_i  out_data_o (gvsp_pkg::out_t)
// cfg      in   cfg_we_i                   cfg_idx_i, cfg_data_i
//
// Create runs S_CREATE for an unused slot, after S_POP for one from the free stack; handle
// commands run S_CHECK then S_EXEC, or S_CHECK alone if the handle fails before the slot
// is read; a full pool or an unknown code goes straight to S_RESP. Tick (unless paused)
// and stop-all walk slots ever used in S_WRD, S_WCHK; tick adds S_WM1, S_WM2 per playing slot.
// Reset is immediate: the high-water count stands in for clearing the slot RAM.
// A result waiting in the output register stalls only the final step of the next command.
module generational_voice_slot_pool #(
  parameter int SLOTS    = 64,
  parameter int GEN_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  gvsp_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output gvsp_pkg::out_t                   out_data_o,
  input  logic                             cfg_we_i,
  input  logic [gvsp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gvsp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import gvsp_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic                used;
    logic [GEN_BITS-1:0] gen;
    logic [PLAY_W-1:0]   play;
    logic [PITCH_W-1:0]  pitch;
    logic [VOL_W-1:0]    vol;
    logic [POS_W-1:0]    pos;
  } entry_t;

  state_e              state_q, state_d;
  in_t                 cmd_q, cmd_d;
  logic [IW-1:0]       sel_q, sel_d;
  logic                fresh_q, fresh_d;
  logic [CW-1:0]       hw_q, hw_d;
  logic [CW-1:0]       fcnt_q, fcnt_d;
  logic [PITCH_W-1:0]  master_q, master_d;
  logic                pause_q, pause_d;
  out_t                res_q, res_d;
  out_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                slot_we, slot_re;
  logic [IW-1:0]       slot_waddr, slot_raddr;
  entry_t              slot_wdata, slot_rdata;
  logic                stk_we, stk_re;
  logic [IW-1:0]       stk_waddr, stk_raddr;
  logic [IW-1:0]       stk_wdata, stk_rdata;

  mac_ctrl_t           mac_ctrl;
  logic [POS_W-1:0]    mac_pos;

  logic [GEN_BITS-1:0] gen_inc, gen_bump;
  logic [CW-1:0]       pop_cnt;
  entry_t              freed, entry_n;
  logic                out_free, walk_last, can_push, hdl_match;

  gvsp_ram #(
    .DEPTH (SLOTS),
    .WIDTH ($bits(entry_t))
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  gvsp_ram #(
    .DEPTH (SLOTS),
    .WIDTH (IW)
  ) u_free_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  gvsp_tick_mac u_tick_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .master_i (master_q),
    .pitch_i  (slot_rdata.pitch),
    .dt_i     (cmd_q.value),
    .pos_i    (slot_rdata.pos),
    .pos_o    (mac_pos)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign out_free  = !out_valid_q || out_ready_i;
  assign pop_cnt   = fcnt_q - CW'(1);
  assign can_push  = 32'(fcnt_q) < SLOTS;
  assign walk_last = (32'(sel_q) + 32'd1) == 32'(hw_q);
  assign hdl_match = slot_rdata.used && (32'(slot_rdata.gen) == 32'(cmd_q.generation));

  // A never-used slot has generation zero; its RAM word was never written.
  assign gen_inc  = (fresh_q ? '0 : slot_rdata.gen) + GEN_BITS'(1);
  assign gen_bump = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

  always_comb begin
    freed       = slot_rdata;
    freed.used  = 1'b0;
    freed.gen   = gen_bump;
    freed.play  = PLAY_STOP;
    freed.pitch = PITCH_UNITY;
    freed.vol   = VOL_UNITY;
    freed.pos   = '0;
  end

  always_comb begin
    master_d = master_q;
    pause_d  = pause_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MASTER_PITCH: master_d = (cfg_data_i > PITCH_MAX) ? PITCH_MAX : cfg_data_i;
        CFG_GLOBAL_PAUSE: pause_d  = cfg_data_i[0];
        default:          master_d = master_q;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    sel_d       = sel_q;
    fresh_d     = fresh_q;
    hw_d        = hw_q;
    fcnt_d      = fcnt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    slot_we     = 1'b0;
    slot_re     = 1'b0;
    slot_waddr  = sel_q;
    slot_raddr  = sel_q;
    slot_wdata  = freed;
    stk_we      = 1'b0;
    stk_re      = 1'b0;
    stk_waddr   = fcnt_q[IW-1:0];
    stk_raddr   = pop_cnt[IW-1:0];
    stk_wdata   = sel_q;
    mac_ctrl    = '0;
    entry_n     = slot_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_data_i;
          fresh_d = 1'b0;
          res_d   = '0;
          sel_d   = '0;
          unique case (in_data_i.action)
            ACT_CREATE: begin
              if (fcnt_q != '0) begin
                stk_re  = 1'b1;
                fcnt_d  = pop_cnt;
                state_d = S_POP;
              end else if (32'(hw_q) < SLOTS) begin
                sel_d   = hw_q[IW-1:0];
                hw_d    = hw_q + CW'(1);
                fresh_d = 1'b1;
                state_d = S_CREATE;
              end else begin
                res_d.status = STAT_FULL;
                state_d      = S_RESP;
              end
            end
            ACT_TICK: begin
              state_d = (pause_q || hw_q == '0) ? S_RESP : S_WRD;
            end
            ACT_STOP_ALL: begin
              state_d = (hw_q == '0) ? S_RESP : S_WRD;
            end
            ACT_RELEASE, ACT_PLAY, ACT_PAUSE, ACT_STOP, ACT_PITCH,
            ACT_VOLUME, ACT_POSITION, ACT_QUERY: begin
              state_d = S_CHECK;
            end
            default: begin
              res_d.status = STAT_INVALID;
              state_d      = S_RESP;
            end
          endcase
        end
      end

      S_CHECK: begin
        res_d.out_index      = cmd_q.slot_index;
        res_d.out_generation = cmd_q.generation;
        if (cmd_q.generation != '0 && 32'(cmd_q.slot_index) < 32'(hw_q)) begin
          sel_d      = IW'(cmd_q.slot_index);
          slot_re    = 1'b1;
          slot_raddr = IW'(cmd_q.slot_index);
          state_d    = S_EXEC;
        end else begin
          res_d.status = STAT_INVALID;
          state_d      = S_RESP;
        end
      end

      S_EXEC: begin
        if (!hdl_match) begin
          res_d.status = STAT_INVALID;
        end else begin
          unique case (cmd_q.action)
            ACT_RELEASE: begin
              entry_n = freed;
              if (can_push) begin
                stk_we = 1'b1;
                fcnt_d = fcnt_q + CW'(1);
              end
            end
            ACT_PLAY:     entry_n.play = PLAY_RUN;
            ACT_PAUSE:    entry_n.play = PLAY_PAUSE;
            ACT_STOP:     entry_n.play = PLAY_STOP;
            ACT_PITCH: begin
              entry_n.pitch = (cmd_q.value > VAL_W'(PITCH_MAX)) ? PITCH_MAX
                                                                : cmd_q.value[PITCH_W-1:0];
            end
            ACT_VOLUME: begin
              entry_n.vol = (cmd_q.value > VAL_W'(VOL_UNITY)) ? VOL_UNITY
                                                              : cmd_q.value[VOL_W-1:0];
            end
            ACT_POSITION: entry_n.pos = cmd_q.value;
            default:      entry_n = slot_rdata;
          endcase
          slot_we           = 1'b1;
          slot_wdata        = entry_n;
          res_d.status      = STAT_OK;
          res_d.play_state  = entry_n.play;
          res_d.position_ms = entry_n.pos;
          res_d.pitch_out   = entry_n.pitch;
          res_d.volume_out  = entry_n.vol;
        end
        state_d = S_RESP;
      end

      S_POP: begin
        sel_d      = stk_rdata;
        slot_re    = 1'b1;
        slot_raddr = stk_rdata;
        state_d    = S_CREATE;
      end

      S_CREATE: begin
        entry_n.used  = 1'b1;
        entry_n.gen   = gen_bump;
        entry_n.play  = cmd_q.auto_play ? PLAY_RUN : PLAY_STOP;
        entry_n.pitch = PITCH_UNITY;
        entry_n.vol   = VOL_UNITY;
        entry_n.pos   = '0;
        slot_we              = 1'b1;
        slot_wdata           = entry_n;
        res_d.status         = STAT_OK;
        res_d.out_index      = IDX_W'(sel_q);
        res_d.out_generation = GEN_W'(gen_bump);
        res_d.play_state     = entry_n.play;
        res_d.position_ms    = entry_n.pos;
        res_d.pitch_out      = entry_n.pitch;
        res_d.volume_out     = entry_n.vol;
        state_d              = S_RESP;
      end

      S_WRD: begin
        slot_re = 1'b1;
        state_d = S_WCHK;
      end

      S_WCHK: begin
        if (cmd_q.action == ACT_TICK && slot_rdata.used && slot_rdata.play == PLAY_RUN) begin
          mac_ctrl.ld_pm = 1'b1;
          state_d        = S_WM1;
        end else begin
          if (cmd_q.action == ACT_STOP_ALL && slot_rdata.used) begin
            slot_we = 1'b1;
            if (can_push) begin
              stk_we = 1'b1;
              fcnt_d = fcnt_q + CW'(1);
            end
          end
          if (walk_last) begin
            state_d = S_RESP;
          end else begin
            sel_d   = sel_q + IW'(1);
            state_d = S_WRD;
          end
        end
      end

      S_WM1: begin
        mac_ctrl.ld_prod = 1'b1;
        state_d          = S_WM2;
      end

      S_WM2: begin
        entry_n.pos = mac_pos;
        slot_we     = 1'b1;
        slot_wdata  = entry_n;
        if (walk_last) begin
          state_d = S_RESP;
        end else begin
          sel_d   = sel_q + IW'(1);
          state_d = S_WRD;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hw_q        <= '0;
      fcnt_q      <= '0;
      master_q    <= PITCH_UNITY;
      pause_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      fcnt_q      <= fcnt_d;
      master_q    <= master_d;
      pause_q     <= pause_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    sel_q   <= sel_d;
    fresh_q <= fresh_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  // Every slot on the free stack has been used before.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fcnt_q <= hw_q)
    else $error("free count exceeds high-water mark");

  assert property (@(posedge clk_i) disable iff (!rst_ni) master_q <= PITCH_MAX)
    else $error("master pitch above clamp");

  // Reads and writes of one RAM are never in the same cycle, so no bypass is needed.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(slot_we && slot_re))
    else $error("slot RAM read and write collide");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result raised outside the response step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_RESP && out_free) |=> out_valid_q && state_q == S_IDLE)
    else $error("response beat not loaded");

endmodule

>>> sv/gvsp_ram.sv
module gvsp_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/gvsp_tick_mac.sv
module gvsp_tick_mac (
  input  logic                                clk_i,
  input  gvsp_pkg::mac_ctrl_t                 ctrl_i,
  input  logic [gvsp_pkg::PITCH_W-1:0]        master_i,
  input  logic [gvsp_pkg::PITCH_W-1:0]        pitch_i,
  input  logic [gvsp_pkg::VAL_W-1:0]          dt_i,
  input  logic [gvsp_pkg::POS_W-1:0]          pos_i,
  output logic [gvsp_pkg::POS_W-1:0]          pos_o
);

  import gvsp_pkg::*;

  logic [PM_W-1:0]   pm_q;
  logic [PROD_W-1:0] prod_q;
  logic [POS_W-1:0]  inc;
  logic [POS_W:0]    sum;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_pm) begin
      pm_q <= PM_W'(pitch_i) * PM_W'(master_i);
    end
    if (ctrl_i.ld_prod) begin
      prod_q <= PROD_W'(dt_i) * PROD_W'(pm_q);
    end
  end

  // The product stays below 2^54, so the increment fits the position width.
  assign inc   = prod_q[TICK_FRAC +: POS_W];
  assign sum   = {1'b0, pos_i} + {1'b0, inc};
  assign pos_o = sum[POS_W] ? POS_MAX : sum[POS_W-1:0];

endmodule
